// ===== hw/rtl/lobm_pkg.sv =====
// lobm_pkg: shared types, constants and helpers for the order book matcher
// no dependencies; used by lobm_mem, lobm_ctrl and limit_order_book_matcher
package lobm_pkg;

    // book geometry
    localparam int NUM_SYMBOLS = 4;
    localparam int BOOK_DEPTH  = 32;
    localparam int SYM_W       = 2;
    localparam int BK_W        = SYM_W + 1;
    localparam int POS_W       = $clog2(BOOK_DEPTH);
    localparam int CNT_W       = $clog2(BOOK_DEPTH + 1);
    localparam int ADDR_W      = BK_W + POS_W;
    localparam int MEM_DEPTH   = 1 << ADDR_W;
    localparam int NUM_BOOKS_W = 1 << BK_W;

    // field widths
    localparam int ID_W    = 24;
    localparam int QTY_W   = 24;
    localparam int PRICE_W = 32;

    localparam logic [PRICE_W-1:0] TOP_TICK = {PRICE_W{1'b1}};

    localparam logic KIND_TRADE  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;
    localparam logic SIDE_BUY    = 1'b0;
    localparam logic SIDE_SELL   = 1'b1;

    typedef enum logic [1:0] {
        FN_ADD_LIMIT  = 2'd0,
        FN_ADD_MARKET = 2'd1,
        FN_CANCEL     = 2'd2,
        FN_MODIFY     = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    // where to go once an entry removal finishes
    typedef enum logic [1:0] {
        CONT_DONE  = 2'd0,
        CONT_INS   = 2'd1,
        CONT_MSELL = 2'd2,
        CONT_MLOOP = 2'd3
    } cont_t;

    typedef struct packed {
        logic [1:0]         func;
        logic [SYM_W-1:0]   symbol;
        logic               side;
        logic [QTY_W-1:0]   quantity;
        logic [PRICE_W-1:0] price;
        logic [ID_W-1:0]    order_id;
    } in_item_t;

    typedef struct packed {
        logic               kind;
        logic [1:0]         status;
        logic [ID_W-1:0]    order_id_res;
        logic [ID_W-1:0]    trade_id;
        logic [ID_W-1:0]    buy_id;
        logic [ID_W-1:0]    sell_id;
        logic [QTY_W-1:0]   fill_quantity;
        logic [PRICE_W-1:0] fill_price;
        logic               last;
    } out_item_t;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [QTY_W-1:0]   qty;
        logic [PRICE_W-1:0] price;
    } entry_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        entry_t            wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    // 24-bit sequence numbers wrap to one
    function automatic logic [ID_W-1:0] bump_id(input logic [ID_W-1:0] v);
        return (v == {ID_W{1'b1}}) ? ID_W'(1) : v + ID_W'(1);
    endfunction

    function automatic logic is_market(input logic [PRICE_W-1:0] p);
        return (p == '0) || (p == TOP_TICK);
    endfunction

    // resting order price first, then incoming order price, else zero
    function automatic logic [PRICE_W-1:0] trade_price(input logic in_sell,
                                                       input logic [PRICE_W-1:0] bp,
                                                       input logic [PRICE_W-1:0] sp);
        logic [PRICE_W-1:0] rp;
        logic [PRICE_W-1:0] op;
        rp = in_sell ? bp : sp;
        op = in_sell ? sp : bp;
        if (!is_market(rp)) begin
            return rp;
        end else if (!is_market(op)) begin
            return op;
        end
        return '0;
    endfunction

endpackage

// ===== hw/rtl/lobm_mem.sv =====
// lobm_mem: order entry storage, one write and one registered read per cycle
// depends on lobm_pkg
module lobm_mem (
    input  logic              aclk,
    input  lobm_pkg::mem_req_t req,
    output lobm_pkg::entry_t   rd_data
);

    lobm_pkg::entry_t mem [lobm_pkg::MEM_DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // read port, registered
    always_ff @(posedge aclk) begin
        if (req.re) begin
            rd_data <= mem[req.raddr];
        end
    end

endmodule

// ===== hw/rtl/lobm_ctrl.sv =====
// lobm_ctrl: sequencer for insert, search, remove and matching over the entry memory
// depends on lobm_pkg; drives lobm_mem through a mem_req_t
module lobm_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lobm_pkg::in_item_t  s_item,
    output logic                res_valid,
    input  logic                res_ready,
    output lobm_pkg::out_item_t res_item,
    output lobm_pkg::mem_req_t  mreq,
    input  lobm_pkg::entry_t    rdata
);

    typedef enum logic [18:0] {
        S_IDLE      = 19'd1 << 0,
        S_ADD_CHK   = 19'd1 << 1,
        S_FIND_RD   = 19'd1 << 2,
        S_FIND_CK   = 19'd1 << 3,
        S_MOD_CHK   = 19'd1 << 4,
        S_REM_RD    = 19'd1 << 5,
        S_REM_WR    = 19'd1 << 6,
        S_INS_START = 19'd1 << 7,
        S_INS_CHK   = 19'd1 << 8,
        S_INS_CMP   = 19'd1 << 9,
        S_M_CB      = 19'd1 << 10,
        S_M_CS      = 19'd1 << 11,
        S_M_RB      = 19'd1 << 12,
        S_M_RS      = 19'd1 << 13,
        S_M_CMP     = 19'd1 << 14,
        S_M_EMIT    = 19'd1 << 15,
        S_M_UPB     = 19'd1 << 16,
        S_M_UPS     = 19'd1 << 17,
        S_DONE      = 19'd1 << 18
    } state_t;

    state_t                          state_reg, state_next;
    lobm_pkg::cont_t                 cont_reg, cont_next;
    lobm_pkg::status_t               status_reg, status_next;
    logic [lobm_pkg::BK_W-1:0]       bk_reg, bk_next;
    logic [lobm_pkg::BK_W-1:0]       fb_reg, fb_next;
    logic [lobm_pkg::BK_W-1:0]       tb_reg, tb_next;
    logic [lobm_pkg::CNT_W-1:0]      i_reg, i_next;
    logic [lobm_pkg::SYM_W-1:0]      sym_reg, sym_next;
    logic                            side_reg, side_next;
    logic [1:0]                      func_reg, func_next;
    logic [lobm_pkg::ID_W-1:0]       oid_reg, oid_next;
    logic [lobm_pkg::ID_W-1:0]       res_oid_reg, res_oid_next;
    logic [lobm_pkg::ID_W-1:0]       next_oid_reg, next_oid_next;
    logic [lobm_pkg::ID_W-1:0]       next_tid_reg, next_tid_next;
    lobm_pkg::entry_t                ent_reg, ent_next;
    lobm_pkg::entry_t                head_b_reg, head_b_next;
    lobm_pkg::entry_t                head_s_reg, head_s_next;
    logic [lobm_pkg::QTY_W-1:0]      q_reg, q_next;
    logic [lobm_pkg::PRICE_W-1:0]    tp_reg, tp_next;
    logic [lobm_pkg::CNT_W-1:0]      cnt_reg [lobm_pkg::NUM_BOOKS_W];

    logic [lobm_pkg::CNT_W-1:0]      cnt_rd;
    logic                            cnt_inc;
    logic                            cnt_dec;
    logic [lobm_pkg::CNT_W-1:0]      i_m1;
    logic [lobm_pkg::CNT_W-1:0]      i_p1;
    logic                            worse;
    logic [lobm_pkg::BK_W-1:0]       tb_calc;

    assign cnt_rd  = cnt_reg[bk_reg];
    assign i_m1    = i_reg - lobm_pkg::CNT_W'(1);
    assign i_p1    = i_reg + lobm_pkg::CNT_W'(1);
    assign worse   = side_reg ? (rdata.price > ent_reg.price) : (rdata.price < ent_reg.price);
    assign tb_calc = {bk_reg[lobm_pkg::BK_W-1:1], side_reg};
    assign s_ready = (state_reg == S_IDLE);

    // sequencer
    always_comb begin
        state_next    = state_reg;
        cont_next     = cont_reg;
        status_next   = status_reg;
        bk_next       = bk_reg;
        fb_next       = fb_reg;
        tb_next       = tb_reg;
        i_next        = i_reg;
        sym_next      = sym_reg;
        side_next     = side_reg;
        func_next     = func_reg;
        oid_next      = oid_reg;
        res_oid_next  = res_oid_reg;
        next_oid_next = next_oid_reg;
        next_tid_next = next_tid_reg;
        ent_next      = ent_reg;
        head_b_next   = head_b_reg;
        head_s_next   = head_s_reg;
        q_next        = q_reg;
        tp_next       = tp_reg;
        mreq          = '0;
        res_valid     = 1'b0;
        res_item      = '0;
        cnt_inc       = 1'b0;
        cnt_dec       = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    func_next     = s_item.func;
                    side_next     = s_item.side;
                    oid_next      = s_item.order_id;
                    status_next   = lobm_pkg::ST_OK;
                    ent_next.id   = '0;
                    ent_next.qty  = s_item.quantity;
                    ent_next.price = s_item.price;
                    if (s_item.func == lobm_pkg::FN_ADD_MARKET) begin
                        ent_next.price = s_item.side ? '0 : lobm_pkg::TOP_TICK;
                    end
                    if (s_item.func == lobm_pkg::FN_ADD_LIMIT ||
                        s_item.func == lobm_pkg::FN_ADD_MARKET) begin
                        if (int'(s_item.symbol) >= lobm_pkg::NUM_SYMBOLS) begin
                            status_next  = lobm_pkg::ST_FULL;
                            res_oid_next = '0;
                            state_next   = S_DONE;
                        end else begin
                            bk_next    = {s_item.symbol, s_item.side};
                            sym_next   = s_item.symbol;
                            state_next = S_ADD_CHK;
                        end
                    end else begin
                        bk_next    = '0;
                        i_next     = '0;
                        state_next = S_FIND_RD;
                    end
                end
            end
            S_ADD_CHK: begin
                if (cnt_rd >= lobm_pkg::CNT_W'(lobm_pkg::BOOK_DEPTH)) begin
                    status_next  = lobm_pkg::ST_FULL;
                    res_oid_next = '0;
                    state_next   = S_DONE;
                end else begin
                    ent_next.id   = next_oid_reg;
                    res_oid_next  = next_oid_reg;
                    next_oid_next = lobm_pkg::bump_id(next_oid_reg);
                    state_next    = S_INS_START;
                end
            end
            // search buy books then sell books, lower symbols first
            S_FIND_RD: begin
                if (i_reg >= cnt_rd) begin
                    i_next = '0;
                    if (int'(bk_reg[lobm_pkg::BK_W-1:1]) == lobm_pkg::NUM_SYMBOLS - 1) begin
                        if (bk_reg[0]) begin
                            status_next  = lobm_pkg::ST_NOT_FOUND;
                            res_oid_next = oid_reg;
                            state_next   = S_DONE;
                        end else begin
                            bk_next = {{lobm_pkg::SYM_W{1'b0}}, 1'b1};
                        end
                    end else begin
                        bk_next = {bk_reg[lobm_pkg::BK_W-1:1] + lobm_pkg::SYM_W'(1), bk_reg[0]};
                    end
                end else begin
                    mreq.re    = 1'b1;
                    mreq.raddr = {bk_reg, i_reg[lobm_pkg::POS_W-1:0]};
                    state_next = S_FIND_CK;
                end
            end
            S_FIND_CK: begin
                if (rdata.id == oid_reg) begin
                    res_oid_next = oid_reg;
                    if (func_reg == lobm_pkg::FN_CANCEL) begin
                        cont_next  = lobm_pkg::CONT_DONE;
                        state_next = S_REM_RD;
                    end else begin
                        tb_next     = tb_calc;
                        fb_next     = bk_reg;
                        sym_next    = bk_reg[lobm_pkg::BK_W-1:1];
                        ent_next.id = oid_reg;
                        cont_next   = lobm_pkg::CONT_INS;
                        if (tb_calc != bk_reg) begin
                            bk_next    = tb_calc;
                            state_next = S_MOD_CHK;
                        end else begin
                            state_next = S_REM_RD;
                        end
                    end
                end else begin
                    i_next     = i_p1;
                    state_next = S_FIND_RD;
                end
            end
            S_MOD_CHK: begin
                if (cnt_rd >= lobm_pkg::CNT_W'(lobm_pkg::BOOK_DEPTH)) begin
                    status_next = lobm_pkg::ST_FULL;
                    state_next  = S_DONE;
                end else begin
                    bk_next    = fb_reg;
                    state_next = S_REM_RD;
                end
            end
            // close the gap at position i: read the next entry in S_REM_RD, write it at i in S_REM_WR
            S_REM_RD: begin
                if (i_p1 < cnt_rd) begin
                    mreq.re    = 1'b1;
                    mreq.raddr = {bk_reg, i_p1[lobm_pkg::POS_W-1:0]};
                    state_next = S_REM_WR;
                end else begin
                    cnt_dec = 1'b1;
                    case (cont_reg)
                        lobm_pkg::CONT_DONE: begin
                            state_next = S_DONE;
                        end
                        lobm_pkg::CONT_INS: begin
                            bk_next    = tb_reg;
                            state_next = S_INS_START;
                        end
                        lobm_pkg::CONT_MSELL: begin
                            state_next = S_M_UPS;
                        end
                        default: begin
                            bk_next    = {sym_reg, lobm_pkg::SIDE_BUY};
                            state_next = S_M_CB;
                        end
                    endcase
                end
            end
            S_REM_WR: begin
                mreq.we    = 1'b1;
                mreq.waddr = {bk_reg, i_reg[lobm_pkg::POS_W-1:0]};
                mreq.wdata = rdata;
                i_next     = i_p1;
                state_next = S_REM_RD;
            end
            // insert from the back, shifting worse entries down
            S_INS_START: begin
                i_next     = cnt_rd;
                state_next = S_INS_CHK;
            end
            S_INS_CHK: begin
                if (i_reg == '0) begin
                    mreq.we    = 1'b1;
                    mreq.waddr = {bk_reg, {lobm_pkg::POS_W{1'b0}}};
                    mreq.wdata = ent_reg;
                    cnt_inc    = 1'b1;
                    bk_next    = {sym_reg, lobm_pkg::SIDE_BUY};
                    state_next = S_M_CB;
                end else begin
                    mreq.re    = 1'b1;
                    mreq.raddr = {bk_reg, i_m1[lobm_pkg::POS_W-1:0]};
                    state_next = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                mreq.we    = 1'b1;
                mreq.waddr = {bk_reg, i_reg[lobm_pkg::POS_W-1:0]};
                if (worse) begin
                    mreq.wdata = rdata;
                    i_next     = i_m1;
                    state_next = S_INS_CHK;
                end else begin
                    mreq.wdata = ent_reg;
                    cnt_inc    = 1'b1;
                    bk_next    = {sym_reg, lobm_pkg::SIDE_BUY};
                    state_next = S_M_CB;
                end
            end
            // matching loop over the two book heads
            S_M_CB: begin
                if (cnt_rd == '0) begin
                    state_next = S_DONE;
                end else begin
                    bk_next    = {sym_reg, lobm_pkg::SIDE_SELL};
                    state_next = S_M_CS;
                end
            end
            S_M_CS: begin
                if (cnt_rd == '0) begin
                    state_next = S_DONE;
                end else begin
                    mreq.re    = 1'b1;
                    mreq.raddr = {sym_reg, lobm_pkg::SIDE_BUY, {lobm_pkg::POS_W{1'b0}}};
                    state_next = S_M_RB;
                end
            end
            S_M_RB: begin
                head_b_next = rdata;
                mreq.re     = 1'b1;
                mreq.raddr  = {sym_reg, lobm_pkg::SIDE_SELL, {lobm_pkg::POS_W{1'b0}}};
                state_next  = S_M_RS;
            end
            S_M_RS: begin
                head_s_next = rdata;
                state_next  = S_M_CMP;
            end
            S_M_CMP: begin
                if (head_b_reg.price < head_s_reg.price) begin
                    state_next = S_DONE;
                end else begin
                    q_next  = (head_b_reg.qty < head_s_reg.qty) ? head_b_reg.qty : head_s_reg.qty;
                    tp_next = lobm_pkg::trade_price(side_reg, head_b_reg.price,
                                                    head_s_reg.price);
                    state_next = S_M_EMIT;
                end
            end
            S_M_EMIT: begin
                res_valid              = 1'b1;
                res_item.kind          = lobm_pkg::KIND_TRADE;
                res_item.status        = lobm_pkg::ST_OK;
                res_item.trade_id      = next_tid_reg;
                res_item.buy_id        = head_b_reg.id;
                res_item.sell_id       = head_s_reg.id;
                res_item.fill_quantity = q_reg;
                res_item.fill_price    = tp_reg;
                if (res_ready) begin
                    next_tid_next   = lobm_pkg::bump_id(next_tid_reg);
                    head_b_next.qty = head_b_reg.qty - q_reg;
                    head_s_next.qty = head_s_reg.qty - q_reg;
                    state_next      = S_M_UPB;
                end
            end
            S_M_UPB: begin
                if (head_b_reg.qty == '0) begin
                    bk_next    = {sym_reg, lobm_pkg::SIDE_BUY};
                    i_next     = '0;
                    cont_next  = lobm_pkg::CONT_MSELL;
                    state_next = S_REM_RD;
                end else begin
                    mreq.we    = 1'b1;
                    mreq.waddr = {sym_reg, lobm_pkg::SIDE_BUY, {lobm_pkg::POS_W{1'b0}}};
                    mreq.wdata = head_b_reg;
                    state_next = S_M_UPS;
                end
            end
            S_M_UPS: begin
                if (head_s_reg.qty == '0) begin
                    bk_next    = {sym_reg, lobm_pkg::SIDE_SELL};
                    i_next     = '0;
                    cont_next  = lobm_pkg::CONT_MLOOP;
                    state_next = S_REM_RD;
                end else begin
                    mreq.we    = 1'b1;
                    mreq.waddr = {sym_reg, lobm_pkg::SIDE_SELL, {lobm_pkg::POS_W{1'b0}}};
                    mreq.wdata = head_s_reg;
                    bk_next    = {sym_reg, lobm_pkg::SIDE_BUY};
                    state_next = S_M_CB;
                end
            end
            S_DONE: begin
                res_valid             = 1'b1;
                res_item.kind         = lobm_pkg::KIND_STATUS;
                res_item.status       = status_reg;
                res_item.order_id_res = res_oid_reg;
                res_item.last         = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            next_oid_reg <= lobm_pkg::ID_W'(1);
            next_tid_reg <= lobm_pkg::ID_W'(1);
            for (int k = 0; k < lobm_pkg::NUM_BOOKS_W; k++) begin
                cnt_reg[k] <= '0;
            end
        end else begin
            state_reg    <= state_next;
            next_oid_reg <= next_oid_next;
            next_tid_reg <= next_tid_next;
            if (cnt_inc) begin
                cnt_reg[bk_reg] <= cnt_rd + lobm_pkg::CNT_W'(1);
            end else if (cnt_dec) begin
                cnt_reg[bk_reg] <= cnt_rd - lobm_pkg::CNT_W'(1);
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        cont_reg    <= cont_next;
        status_reg  <= status_next;
        bk_reg      <= bk_next;
        fb_reg      <= fb_next;
        tb_reg      <= tb_next;
        i_reg       <= i_next;
        sym_reg     <= sym_next;
        side_reg    <= side_next;
        func_reg    <= func_next;
        oid_reg     <= oid_next;
        res_oid_reg <= res_oid_next;
        ent_reg     <= ent_next;
        head_b_reg  <= head_b_next;
        head_s_reg  <= head_s_next;
        q_reg       <= q_next;
        tp_reg      <= tp_next;
    end

endmodule

// ===== hw/rtl/limit_order_book_matcher.sv =====
// limit_order_book_matcher: top level with sequencer, entry memory and result register
// depends on lobm_pkg, lobm_mem, lobm_ctrl
//
// Usage:
//   s_valid/s_ready/s_item carry one request item: add limit, add market,
//   cancel or modify. One item is worked on at a time; s_ready is high only
//   while the sequencer waits for work.
//   m_valid/m_ready/m_item carry results: zero or more trade reports, then
//   one status item with last set.
//   Operation: every step walks the entry memory (one port read, one port
//   write, registered read). An add shifts worse entries on insert, then
//   each fill may remove a head entry and shift the rest of its book up;
//   cancel and modify first search the books, up to 256 entries.
//   Results leave through a one-item output register, so the sequencer
//   keeps going while one result waits; a stalled m_ready holds the
//   sequencer at its next result.
//   Reset (aresetn low, synchronous) empties all books and sets the next
//   order id and the next trade number to one. The memory needs no clearing.
module limit_order_book_matcher (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lobm_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output lobm_pkg::out_item_t m_item
);

    lobm_pkg::mem_req_t  mreq;
    lobm_pkg::entry_t    rdata;
    lobm_pkg::out_item_t res_item;
    logic                res_valid;
    logic                res_ready;
    logic                m_valid_reg;
    lobm_pkg::out_item_t m_item_reg;

    lobm_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item),
        .mreq      (mreq),
        .rdata     (rdata)
    );

    lobm_mem u_mem (
        .aclk    (aclk),
        .req     (mreq),
        .rd_data (rdata)
    );

    // output register
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_item_reg <= res_item;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // checks
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken twice without finishing");

    a_no_result_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !res_valid)
        else $error("result produced while idle");

    a_last_is_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.last |-> m_item.kind == lobm_pkg::KIND_STATUS)
        else $error("last flag on a trade report");

endmodule
